FILE: rtl/telnet_iac_strip_ring_buffer_assert.svh
// Assertion macros used by the checker file of the IAC stripper.
`ifndef TELNET_IAC_STRIP_RING_BUFFER_ASSERT_SVH
`define TELNET_IAC_STRIP_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TISRB_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is low.
`define TISRB_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: label");

`endif

FILE: rtl/tisrb_pkg.sv
// Shared types and constants of the telnet IAC stripper with ring buffer.
package tisrb_pkg;

    localparam int BUF_DEPTH_DEF = 128;

    localparam logic [7:0] IAC_BYTE = 8'hFF;

    // Request operation codes
    localparam logic [2:0] OP_BYTE       = 3'd0;
    localparam logic [2:0] OP_READ       = 3'd1;
    localparam logic [2:0] OP_PEEK       = 3'd2;
    localparam logic [2:0] OP_CONNECT    = 3'd3;
    localparam logic [2:0] OP_DISCONNECT = 3'd4;

    // Filter phases
    localparam logic [1:0] PH_DATA = 2'd0;
    localparam logic [1:0] PH_CMD  = 2'd1;
    localparam logic [1:0] PH_OPT  = 2'd2;

    localparam logic [6:0] FILL_MAX = 7'd127;

    typedef struct packed {
        logic       session_open;
        logic       overflow;
        logic [6:0] fill_count;
        logic       data_valid;
        logic [7:0] data_out;
    } t_result;

endpackage

FILE: rtl/tisrb_core.sv
// Session state, IAC filter, ring buffer memory and result stage.
module tisrb_core #(
    parameter int BUFFER_DEPTH = tisrb_pkg::BUF_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_op,
    input  logic [7:0]        i_byte,
    output logic              o_valid,
    input  logic              i_take,
    output tisrb_pkg::t_result o_res
);
    import tisrb_pkg::*;

    localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = (IW + 1 > 8) ? IW + 1 : 8;

    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_rd_data;

    logic          r_conn, n_conn;
    logic [IW-1:0] r_wr, n_wr;
    logic [IW-1:0] r_rd, n_rd;
    logic [1:0]    r_ph, n_ph;

    logic          r_valid;
    logic          r_dv;
    logic [6:0]    r_fill;
    logic          r_ovf;
    logic          r_sess;

    logic          accept;
    logic          wr_en;
    logic          rd_ok;
    logic          ovf;
    logic [IW-1:0] wr_inc;
    logic [IW-1:0] rd_inc;
    logic [CW-1:0] diff;
    logic [6:0]    fill;

    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;

    assign wr_inc = (r_wr == IW'(BUFFER_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign rd_inc = (r_rd == IW'(BUFFER_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_comb begin
        n_conn = r_conn;
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_ph   = r_ph;
        ovf    = 1'b0;
        wr_en  = 1'b0;
        rd_ok  = 1'b0;
        case (i_op) inside
            OP_BYTE: begin
                if (r_conn) begin
                    case (r_ph)
                        PH_DATA: begin
                            if (i_byte == IAC_BYTE) begin
                                n_ph = PH_CMD;
                            end else begin
                                wr_en = 1'b1;
                                n_wr  = wr_inc;
                                if (wr_inc == r_rd) begin
                                    // store, then drop the session
                                    ovf    = 1'b1;
                                    n_conn = 1'b0;
                                    n_wr   = '0;
                                    n_rd   = '0;
                                    n_ph   = PH_DATA;
                                end
                            end
                        end
                        PH_CMD:  n_ph = PH_OPT;
                        PH_OPT:  n_ph = PH_DATA;
                        default: begin
                            n_conn = 1'b0;
                            n_wr   = '0;
                            n_rd   = '0;
                            n_ph   = PH_DATA;
                        end
                    endcase
                end
            end
            OP_READ, OP_PEEK: begin
                if (r_conn && (r_wr != r_rd)) begin
                    rd_ok = 1'b1;
                    if (i_op == OP_READ) begin
                        n_rd = rd_inc;
                    end
                end
            end
            OP_CONNECT: n_conn = 1'b1;
            OP_DISCONNECT: begin
                n_conn = 1'b0;
                n_wr   = '0;
                n_rd   = '0;
                n_ph   = PH_DATA;
            end
            default: ;
        endcase
    end

    // Bytes waiting after this request, saturated to the field width
    always_comb begin
        if (n_wr >= n_rd) begin
            diff = CW'(n_wr) - CW'(n_rd);
        end else begin
            diff = CW'(BUFFER_DEPTH) - CW'(n_rd) + CW'(n_wr);
        end
        if (!n_conn) begin
            fill = '0;
        end else if (diff > CW'(FILL_MAX)) begin
            fill = FILL_MAX;
        end else begin
            fill = diff[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem[r_wr] <= i_byte;
        end
        if (accept) begin
            r_rd_data <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn  <= 1'b0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_ph    <= PH_DATA;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_conn  <= n_conn;
                r_wr    <= n_wr;
                r_rd    <= n_rd;
                r_ph    <= n_ph;
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dv   <= rd_ok;
            r_fill <= fill;
            r_ovf  <= ovf;
            r_sess <= n_conn;
        end
    end

    assign o_valid             = r_valid;
    assign o_res.data_out      = r_dv ? r_rd_data : 8'd0;
    assign o_res.data_valid    = r_dv;
    assign o_res.fill_count    = r_fill;
    assign o_res.overflow      = r_ovf;
    assign o_res.session_open  = r_sess;

endmodule

FILE: rtl/tisrb_skid.sv
// Two-entry skid buffer that registers the result channel in both directions.
module tisrb_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  tisrb_pkg::t_result i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output tisrb_pkg::t_result o_data
);
    import tisrb_pkg::*;

    logic    r_out_valid;
    t_result r_out;
    logic    r_sk_valid;
    t_result r_sk;
    logic    in_fire;

    assign o_ready = !r_sk_valid;
    assign in_fire = i_valid && !r_sk_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_sk_valid ? r_sk : i_data;
        end else if (in_fire) begin
            r_sk <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: rtl/telnet_iac_strip_ring_buffer.sv
// Top level of the telnet IAC stripper with receive ring buffer.
// A request accepted passes the core's result stage, then the skid buffer's
//   output register, before it reaches the result port.
// Throughput: one request per cycle unless results back up; each request takes
//   one compare, a pointer update and one single-port-per-side memory access.
// Reset: synchronous, active low; clears session, pointers, filter phase and
//   both output stages. The byte memory is not cleared and needs no sweep.
module telnet_iac_strip_ring_buffer #(
    parameter int BUFFER_DEPTH = tisrb_pkg::BUF_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [2:0] operation, [10:3] byte_in, rest zero
    // result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // [7:0] data_out, [8] data_valid,
                                         // [15:9] fill_count, [16] overflow,
                                         // [17] session_open, rest zero
);
    import tisrb_pkg::*;

    logic    core_valid;
    logic    skid_ready;
    t_result core_res;
    t_result out_res;

    // Filter, pointers and memory; results land in the core's result stage.
    tisrb_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_op    (i_s_axis_tdata[2:0]),
        .i_byte  (i_s_axis_tdata[10:3]),
        .o_valid (core_valid),
        .i_take  (skid_ready),
        .o_res   (core_res)
    );

    // Break the ready path so a stalled consumer never gates new requests
    // combinationally.
    tisrb_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (core_valid),
        .o_ready (skid_ready),
        .i_data  (core_res),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_res)
    );

    // Pack result fields from the lowest bit up, pad to whole bytes.
    assign o_m_axis_tdata = {6'd0, out_res.session_open, out_res.overflow,
                             out_res.fill_count, out_res.data_valid,
                             out_res.data_out};

endmodule

FILE: rtl/tisrb_checker.sv
// Port-level checker for the IAC stripper, bound to the top level.
`include "telnet_iac_strip_ring_buffer_assert.svh"

module tisrb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_tvalid,
    input logic        i_out_tready,
    input logic [23:0] i_out_tdata
);
    import tisrb_pkg::*;

    // An overflow closes the session and empties the buffer view.
    `TISRB_ASSERT_IMPLY(a_ovf_closes, i_clk, i_rst_n, i_out_tvalid && i_out_tdata[16], !i_out_tdata[17] && (i_out_tdata[15:9] == 7'd0))
    // No session means nothing waiting.
    `TISRB_ASSERT_IMPLY(a_idle_empty, i_clk, i_rst_n, i_out_tvalid && !i_out_tdata[17], i_out_tdata[15:9] == 7'd0)
    // Data is zero unless it holds a buffered byte.
    `TISRB_ASSERT_IMPLY(a_data_zero, i_clk, i_rst_n, i_out_tvalid && !i_out_tdata[8], i_out_tdata[7:0] == 8'd0)
    // A stalled result holds.
    `TISRB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_tvalid && !i_out_tready, i_out_tvalid && $stable(i_out_tdata))

endmodule

bind telnet_iac_strip_ring_buffer tisrb_checker u_tisrb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_tvalid (o_m_axis_tvalid),
    .i_out_tready (i_m_axis_tready),
    .i_out_tdata  (o_m_axis_tdata)
);

FILE: dv/telnet_iac_strip_ring_buffer_tb.sv
// Self-checking testbench of the telnet IAC stripper with receive ring buffer.
module telnet_iac_strip_ring_buffer_tb;
    import tisrb_pkg::*;

    localparam int IDLE_PCT      = 25;    // chance per cycle that a side idles
    localparam int ITEM_TARGET   = 1600;  // random requests to generate
    localparam int CALM_FIRST    = 1000;  // request count where idling stops
    localparam int CALM_LAST     = 1300;  // request count where idling resumes
    localparam int HOLD_AT       = 400;   // request count that starts the long stall
    localparam int HOLD_CYCLES   = 300;   // length of the long result-side stall
    localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
    localparam int DRAIN_CYCLES  = 10;    // settle time after the last result

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;     // [2:0] operation, [10:3] byte_in, rest zero
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;          // [7:0] data_out, [8] data_valid,
                                          // [15:9] fill_count, [16] overflow,
                                          // [17] session_open, rest zero

    telnet_iac_strip_ring_buffer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Requests waiting to be offered, and results predicted but not yet seen.
    logic [15:0] req_queue[$];
    t_result     result_queue[$];

    int req_taken   = 0;   // requests accepted so far
    int req_made    = 0;   // counted requests generated (unused codes excluded)
    int fail_count  = 0;
    int quiet_count = 0;   // cycles with no handshake on either side
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    // Drop idling on both sides for a stretch of requests.
    wire calm = (req_taken >= CALM_FIRST) && (req_taken < CALM_LAST);

    // Shadow copy of the stripper state. The ring is 128 deep, so the 7-bit
    // indices wrap on their own and their difference is the fill count.
    logic [7:0] ring_mem [BUF_DEPTH_DEF];
    logic [6:0] ring_wr;
    logic [6:0] ring_rd;
    logic [1:0] iac_phase;
    logic       session_up;

    function automatic void drop_session();
        session_up = 1'b0;
        ring_wr    = '0;
        ring_rd    = '0;
        iac_phase  = PH_DATA;
    endfunction

    // Advance the shadow state by one request and return the result it yields.
    function automatic t_result strip_and_buffer(logic [2:0] op, logic [7:0] rx);
        t_result res;
        res = '0;
        case (op)
            OP_BYTE: begin
                if (session_up) begin
                    case (iac_phase)
                        PH_DATA: begin
                            if (rx == IAC_BYTE) begin
                                iac_phase = PH_CMD;
                            end else begin
                                // store first, then check for the pointer clash
                                ring_mem[ring_wr] = rx;
                                ring_wr = ring_wr + 7'd1;
                                if (ring_wr == ring_rd) begin
                                    drop_session();
                                    res.overflow = 1'b1;
                                end
                            end
                        end
                        PH_CMD:  iac_phase = PH_OPT;
                        PH_OPT:  iac_phase = PH_DATA;
                        default: drop_session();
                    endcase
                end
            end
            OP_READ, OP_PEEK: begin
                if (session_up && ring_wr != ring_rd) begin
                    res.data_out   = ring_mem[ring_rd];
                    res.data_valid = 1'b1;
                    if (op == OP_READ)
                        ring_rd = ring_rd + 7'd1;
                end
            end
            OP_CONNECT:    session_up = 1'b1;
            OP_DISCONNECT: drop_session();
            default: ;
        endcase
        res.fill_count   = session_up ? ring_wr - ring_rd : 7'd0;
        res.session_open = session_up;
        return res;
    endfunction

    function automatic void queue_req(logic [2:0] op, logic [7:0] rx);
        req_queue.push_back({5'd0, rx, op});
        if (op <= OP_DISCONNECT)
            req_made++;
    endfunction

    function automatic void queue_iac_triplet();
        queue_req(OP_BYTE, IAC_BYTE);
        queue_req(OP_BYTE, 8'($urandom_range(0, 255)));
        queue_req(OP_BYTE, 8'($urandom_range(0, 255)));
    endfunction

    // Plain data byte, with an occasional IAC command in between.
    function automatic void queue_data_byte();
        if ($urandom_range(0, 99) < 8)
            queue_iac_triplet();
        else
            queue_req(OP_BYTE, 8'($urandom_range(0, 254)));
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Request driver: advance to the next pending request when the current one
    // is taken, idling at random outside the calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                result_queue.push_back(strip_and_buffer(i_s_axis_tdata[2:0],
                                                        i_s_axis_tdata[10:3]));
                req_taken <= req_taken + 1;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (req_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= req_queue.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result-side ready: hold off once for a long stretch so the block backs
    // up and stalls its request side; otherwise idle at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && req_taken >= HOLD_AT) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Result monitor: compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[17:0]);
            if (result_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h",
                         $time, o_m_axis_tdata);
                fail_count++;
            end else begin
                want = result_queue.pop_front();
                check_field("data_out",     want.data_out,     got.data_out);
                check_field("data_valid",   want.data_valid,   got.data_valid);
                check_field("fill_count",   want.fill_count,   got.fill_count);
                check_field("overflow",     want.overflow,     got.overflow);
                check_field("session_open", want.session_open, got.session_open);
                check_field("tdata pad",    0,                 o_m_axis_tdata[23:18]);
            end
        end
    end

    // Watchdog: end the run if no handshake happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
            if (quiet_count >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int kind;
        int steps;
        int pick;

        foreach (ring_mem[k])
            ring_mem[k] = '0;
        drop_session();

        // Directed: idle requests, double connect, IAC handling, empty reads,
        // unused codes and disconnects with and without a session.
        queue_req(OP_READ, 8'hAA);
        queue_req(OP_PEEK, 8'h55);
        queue_req(OP_BYTE, 8'hFF);          // byte while idle
        queue_req(OP_CONNECT, 8'h00);
        queue_req(OP_CONNECT, 8'hFF);       // second connect leaves the session open
        queue_req(OP_READ, 8'h00);          // empty read
        queue_req(OP_PEEK, 8'h00);          // empty peek
        queue_req(OP_BYTE, 8'h00);
        queue_req(OP_BYTE, IAC_BYTE);
        queue_req(OP_BYTE, IAC_BYTE);       // command byte equal to IAC
        queue_req(OP_BYTE, IAC_BYTE);       // option byte equal to IAC
        queue_req(OP_BYTE, 8'h80);
        queue_req(OP_BYTE, 8'h7F);
        queue_req(OP_BYTE, 8'hFE);
        queue_req(OP_PEEK, 8'h00);
        queue_req(OP_READ, 8'h00);
        queue_req(3'd5, 8'hFF);
        queue_req(3'd6, 8'h0F);
        queue_req(3'd7, 8'hF0);
        queue_req(OP_READ, 8'h00);
        queue_req(OP_READ, 8'h00);
        queue_req(OP_READ, 8'h00);          // drained again
        queue_req(OP_DISCONNECT, 8'h00);
        queue_req(OP_DISCONNECT, 8'h00);    // disconnect with no session

        // Random: mostly connected sessions with mixed traffic, some long fills
        // that wrap or overflow the ring, and a share of raw noise.
        while (req_made < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                queue_req(OP_CONNECT, 8'($urandom_range(0, 255)));
                steps = $urandom_range(10, 80);
                repeat (steps) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                        queue_data_byte();
                    else if (pick < 75)
                        queue_req(OP_READ, 8'($urandom_range(0, 255)));
                    else if (pick < 90)
                        queue_req(OP_PEEK, 8'($urandom_range(0, 255)));
                    else if (pick < 93)
                        queue_req(OP_CONNECT, 8'($urandom_range(0, 255)));
                    else if (pick < 96)
                        queue_req(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)));
                    else if (pick < 99)
                        queue_req(OP_BYTE, 8'($urandom_range(0, 255)));
                    else
                        queue_req(OP_DISCONNECT, 8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 99) < 30)
                    queue_req(OP_DISCONNECT, 8'($urandom_range(0, 255)));
            end else if (kind < 65) begin
                // long fill that can drive the write pointer into the read pointer
                queue_req(OP_CONNECT, 8'h00);
                steps = 127 + $urandom_range(1, 8);
                repeat (steps)
                    queue_data_byte();
                repeat ($urandom_range(1, 4))
                    queue_req(OP_READ, 8'($urandom_range(0, 255)));
            end else if (kind < 75) begin
                // fill, drain part, fill again so the pointers wrap
                queue_req(OP_CONNECT, 8'h00);
                repeat ($urandom_range(90, 120))
                    queue_req(OP_BYTE, 8'($urandom_range(0, 254)));
                repeat ($urandom_range(60, 100))
                    queue_req(OP_READ, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(60, 100))
                    queue_data_byte();
                repeat (20)
                    queue_req($urandom_range(0, 1) ? OP_READ : OP_PEEK, 8'h00);
            end else begin
                repeat ($urandom_range(5, 20))
                    queue_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
        end

        // Hold reset, then release it for the rest of the run.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: wait for every request to go out and every result to return.
        while (req_queue.size() != 0 || i_s_axis_tvalid || result_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
